### rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// Shared types and constants for the sparse polynomial adder.
// ----------------------------------------------------------------------------
package spa_pkg;

   // store geometry
   localparam int MAX_TERMS = 32;
   localparam int IDX_W     = 5;   // index into one store
   localparam int CNT_W     = 6;   // count, holds MAX_TERMS itself

   // request action codes
   localparam logic [1:0] ACT_LOAD_A = 2'd0;
   localparam logic [1:0] ACT_LOAD_B = 2'd1;
   localparam logic [1:0] ACT_RUN    = 2'd2;

   // command kinds carried through the queue
   localparam logic [1:0] KIND_LOAD_A = 2'd0;
   localparam logic [1:0] KIND_LOAD_B = 2'd1;
   localparam logic [1:0] KIND_RUN    = 2'd2;

   // command queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [1:0]          kind;
      logic signed [15:0]  coeff;
      logic [15:0]         exp;
   } cmd_type;

endpackage

### rtl/core/spa_front.sv
// ----------------------------------------------------------------------------
// spa_front
// Accepts request items, decodes the action and pushes a command to the queue.
// ----------------------------------------------------------------------------
module spa_front
   import spa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic signed [15:0]  req_term_coeff,
   input  logic [15:0]         req_term_exp,
   input  logic                q_full,
   output logic                push_valid,
   output cmd_type             push_cmd
);

   // set once reset is released; no item is taken before that
   logic armed_ff, armed_in;

   assign armed_in = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   assign req_ready = armed_ff && !q_full;

   always_comb begin
      push_valid     = 1'b0;
      push_cmd.coeff = req_term_coeff;
      push_cmd.exp   = req_term_exp;
      push_cmd.kind  = KIND_LOAD_A;
      if (req_valid && req_ready) begin
         case (req_action)
            ACT_LOAD_A: begin
               push_valid    = 1'b1;
               push_cmd.kind = KIND_LOAD_A;
            end
            ACT_LOAD_B: begin
               push_valid    = 1'b1;
               push_cmd.kind = KIND_LOAD_B;
            end
            ACT_RUN: begin
               push_valid    = 1'b1;
               push_cmd.kind = KIND_RUN;
            end
            default: begin
               // unused action code: item taken and dropped
               push_valid = 1'b0;
            end
         endcase
      end
   end

endmodule

### rtl/core/spa_queue.sv
// ----------------------------------------------------------------------------
// spa_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module spa_queue
   import spa_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   input  cmd_type  push_cmd,
   output logic     full,
   output logic     pop_valid,
   input  logic     pop,
   output cmd_type  pop_cmd
);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];

   assign do_push = push_valid && !full;
   assign do_pop  = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### rtl/core/spa_back.sv
// ----------------------------------------------------------------------------
// spa_back
// Term stores, merge engine and result register.
// ----------------------------------------------------------------------------
module spa_back
   import spa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  cmd_type             q_cmd,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [16:0]  rsp_sum_coeff,
   output logic [15:0]         rsp_sum_exp,
   output logic                rsp_last_term,
   output logic                rsp_empty_sum,
   output logic                rsp_overflow
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_MERGE = 1'b1;

   // stores: {coeff, exp}
   logic [31:0]        mem_a [MAX_TERMS];
   logic [31:0]        mem_b [MAX_TERMS];
   logic [31:0]        rd_a_ff, rd_b_ff;

   logic               state_ff, state_in;
   logic [CNT_W-1:0]   cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [CNT_W-1:0]   i_ff, i_in, j_ff, j_in;
   logic               drop_ff, drop_in;
   logic               wr_a, wr_b;

   // held term: emitted once the next one (or the end) is known
   logic               pend_valid_ff, pend_valid_in;
   logic signed [16:0] pend_coeff_ff, pend_coeff_in;
   logic [15:0]        pend_exp_ff, pend_exp_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [16:0] out_coeff_ff, out_coeff_in;
   logic [15:0]        out_exp_ff, out_exp_in;
   logic               out_last_ff, out_last_in;
   logic               out_empty_ff, out_empty_in;
   logic               out_ovf_ff, out_ovf_in;
   logic               out_load, out_free;

   logic signed [16:0] a_coeff, b_coeff, ab_sum;
   logic [15:0]        a_exp, b_exp;
   logic               a_has, b_has;

   assign a_coeff = 17'(signed'(rd_a_ff[31:16]));
   assign b_coeff = 17'(signed'(rd_b_ff[31:16]));
   assign a_exp   = rd_a_ff[15:0];
   assign b_exp   = rd_b_ff[15:0];
   assign ab_sum  = a_coeff + b_coeff;
   assign a_has   = (i_ff < cnt_a_ff);
   assign b_has   = (j_ff < cnt_b_ff);
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in      = state_ff;
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      drop_in       = drop_ff;
      wr_a          = 1'b0;
      wr_b          = 1'b0;
      q_pop         = 1'b0;
      pend_valid_in = pend_valid_ff;
      pend_coeff_in = pend_coeff_ff;
      pend_exp_in   = pend_exp_ff;
      out_load      = 1'b0;
      out_coeff_in  = pend_coeff_ff;
      out_exp_in    = pend_exp_ff;
      out_last_in   = 1'b0;
      out_empty_in  = 1'b0;
      out_ovf_in    = drop_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_cmd.kind)
                  KIND_LOAD_A: begin
                     if (cnt_a_ff < CNT_W'(MAX_TERMS)) begin
                        wr_a     = 1'b1;
                        cnt_a_in = cnt_a_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  KIND_LOAD_B: begin
                     if (cnt_b_ff < CNT_W'(MAX_TERMS)) begin
                        wr_b     = 1'b1;
                        cnt_b_in = cnt_b_ff + 1'b1;
                     end else begin
                        drop_in = 1'b1;
                     end
                  end
                  KIND_RUN: begin
                     // heads at index 0 are read at this edge
                     state_in = ST_MERGE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               if (!a_has && !b_has) begin
                  out_load    = 1'b1;
                  out_last_in = 1'b1;
                  if (!pend_valid_ff) begin
                     out_coeff_in = '0;
                     out_exp_in   = '0;
                     out_empty_in = 1'b1;
                  end
                  cnt_a_in      = '0;
                  cnt_b_in      = '0;
                  drop_in       = 1'b0;
                  i_in          = '0;
                  j_in          = '0;
                  pend_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end else begin
                  logic               take_a, take_b, new_valid;
                  logic signed [16:0] new_coeff;
                  logic [15:0]        new_exp;
                  take_a    = 1'b0;
                  take_b    = 1'b0;
                  new_valid = 1'b1;
                  new_coeff = a_coeff;
                  new_exp   = a_exp;
                  if (a_has && b_has) begin
                     if (a_exp > b_exp) begin
                        take_a = 1'b1;
                     end else if (a_exp < b_exp) begin
                        take_b    = 1'b1;
                        new_coeff = b_coeff;
                        new_exp   = b_exp;
                     end else begin
                        take_a    = 1'b1;
                        take_b    = 1'b1;
                        new_coeff = ab_sum;
                        new_valid = (ab_sum != '0);
                     end
                  end else if (a_has) begin
                     take_a = 1'b1;
                  end else begin
                     take_b    = 1'b1;
                     new_coeff = b_coeff;
                     new_exp   = b_exp;
                  end
                  i_in = take_a ? i_ff + 1'b1 : i_ff;
                  j_in = take_b ? j_ff + 1'b1 : j_ff;
                  if (new_valid) begin
                     out_load      = pend_valid_ff;
                     pend_valid_in = 1'b1;
                     pend_coeff_in = new_coeff;
                     pend_exp_in   = new_exp;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_a_ff      <= '0;
         cnt_b_ff      <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         drop_ff       <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_a_ff      <= cnt_a_in;
         cnt_b_ff      <= cnt_b_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_coeff_ff <= pend_coeff_in;
      pend_exp_ff   <= pend_exp_in;
      if (out_load) begin
         out_coeff_ff <= out_coeff_in;
         out_exp_ff   <= out_exp_in;
         out_last_ff  <= out_last_in;
         out_empty_ff <= out_empty_in;
         out_ovf_ff   <= out_ovf_in;
      end
   end

   // store A: one write, one registered read at the next head index
   always_ff @(posedge clock) begin
      if (wr_a) begin
         mem_a[cnt_a_ff[IDX_W-1:0]] <= {q_cmd.coeff, q_cmd.exp};
      end
      rd_a_ff <= mem_a[i_in[IDX_W-1:0]];
   end

   // store B
   always_ff @(posedge clock) begin
      if (wr_b) begin
         mem_b[cnt_b_ff[IDX_W-1:0]] <= {q_cmd.coeff, q_cmd.exp};
      end
      rd_b_ff <= mem_b[j_in[IDX_W-1:0]];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sum_coeff = out_coeff_ff;
   assign rsp_sum_exp   = out_exp_ff;
   assign rsp_last_term = out_last_ff;
   assign rsp_empty_sum = out_empty_ff;
   assign rsp_overflow  = out_ovf_ff;

endmodule

### rtl/core/sparse_polynomial_add_top.sv
// A load passes the queue and is stored when the back end pops it; a run's
//   first term passes the queue, store reads, held term and result register
//   (back end idle). Loads are taken one per cycle while the queue is not
//   full; a run holds the back end for its pop, at most a step per term
//   and a closing step, plus rsp_ready stalls; at most one term per cycle.
// Reset: synchronous, active high; clears counts, overflow flag and queue.
// ----------------------------------------------------------------------------
// sparse_polynomial_add_top
// Sparse polynomial adder: loads two term lists, merges them on a run.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_top
   import spa_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic signed [15:0]  req_term_coeff,
   input  logic [15:0]         req_term_exp,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [16:0]  rsp_sum_coeff,
   output logic [15:0]         rsp_sum_exp,
   output logic                rsp_last_term,
   output logic                rsp_empty_sum,
   output logic                rsp_overflow
);

   // front -> queue
   logic     push_valid;
   cmd_type  push_cmd;
   logic     q_full;

   // queue -> back
   logic     q_valid;
   logic     q_pop;
   cmd_type  q_cmd;

   // Front end: decodes each item; unknown actions are taken and dropped.
   spa_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_term_coeff (req_term_coeff),
      .req_term_exp   (req_term_exp),
      .q_full         (q_full),
      .push_valid     (push_valid),
      .push_cmd       (push_cmd)
   );

   // Command queue: lets up to QUEUE_DEPTH commands arrive while a run drains.
   spa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_cmd    (q_cmd)
   );

   // Back end: stores, in-order merge, and the result register. One term is
   // held back so the last one of a run can be flagged once the end is seen.
   // No items are taken from the queue while a run is in progress.
   spa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sum_coeff (rsp_sum_coeff),
      .rsp_sum_exp   (rsp_sum_exp),
      .rsp_last_term (rsp_last_term),
      .rsp_empty_sum (rsp_empty_sum),
      .rsp_overflow  (rsp_overflow)
   );

endmodule

### dv/sparse_polynomial_add_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sparse_polynomial_add_top_tb
// Self-checking bench for the sparse polynomial adder. Term lists for both
// polynomials are streamed in, a run command merges them, and every emitted
// sum term is compared field by field against a local merge predictor. The
// bench steps through phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_top_tb
   import spa_pkg::*;
();

   localparam int CLK_PERIOD    = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 20;    // slack after the last term, covers run latency
   localparam int PHASE_ITEMS   = 4;     // random load/run items per phase, at least

   // action 3 has no meaning to the block; used as noise
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // one request item as presented on the req_ channel
   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] coeff;
      logic [15:0]        expo;
   } req_item_type;

   // one sum term as expected on the rsp_ channel
   typedef struct packed {
      logic signed [16:0] coeff;
      logic [15:0]        expo;
      logic               last;
      logic               empty;
      logic               ovf;
   } sum_term_type;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action     = ACT_LOAD_A;
   logic signed [15:0] req_term_coeff = '0;
   logic [15:0]        req_term_exp   = '0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic signed [16:0] rsp_sum_coeff;
   logic [15:0]        rsp_sum_exp;
   logic               rsp_last_term;
   logic               rsp_empty_sum;
   logic               rsp_overflow;

   sparse_polynomial_add_top u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_term_coeff (req_term_coeff),
      .req_term_exp   (req_term_exp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sum_coeff  (rsp_sum_coeff),
      .rsp_sum_exp    (rsp_sum_exp),
      .rsp_last_term  (rsp_last_term),
      .rsp_empty_sum  (rsp_empty_sum),
      .rsp_overflow   (rsp_overflow)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   req_item_type req_backlog [$];     // items waiting for the driver
   sum_term_type sum_terms_due [$];   // predicted terms, oldest first

   // predictor copy of the two term stores
   logic signed [15:0] a_coeff [MAX_TERMS];
   logic [15:0]        a_expo  [MAX_TERMS];
   logic signed [15:0] b_coeff [MAX_TERMS];
   logic [15:0]        b_expo  [MAX_TERMS];
   int                 a_count      = 0;
   int                 b_count      = 0;
   logic               load_dropped = 1'b0;

   int   send_idle_pct  = 0;       // chance in 100 that the sender holds off
   int   recv_stall_pct = 0;       // chance in 100 that rsp_ready is low
   logic req_taken      = 1'b0;    // request accepted at the last rising edge

   int cycle_count   = 0;
   int mismatches    = 0;
   int items_queued  = 0;
   int useful_items  = 0;          // items queued, not counting noise
   int runs_seen     = 0;
   int overflow_runs = 0;
   int empty_runs    = 0;
   int terms_seen    = 0;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------------
   // Failure report: one line, one count
   // ------------------------------------------------------------------------
   task automatic flag_mismatch(string what, int got, int want);
      mismatches++;
      $display("ERROR cycle %0d term %0d: %s, got %0d expected %0d",
               cycle_count, terms_seen, what, got, want);
   endtask

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic sum_term_type make_term(logic signed [16:0] c, logic [15:0] e);
      sum_term_type t;
      t.coeff = c;
      t.expo  = e;
      t.last  = 1'b0;
      t.empty = 1'b0;
      t.ovf   = load_dropped;
      return t;
   endfunction

   // Merge both stores as sorted streams, larger exponent first. Equal heads
   // are added and a zero sum vanishes. Note the walk follows the load order
   // even when a list was not loaded in descending order.
   task automatic merge_polys();
      sum_term_type run_terms [$];
      sum_term_type t;
      int        ia;
      int        ib;
      int        k;
      int        total;
      ia = 0;
      ib = 0;
      while (ia < a_count && ib < b_count) begin
         if (a_expo[ia] > b_expo[ib]) begin
            run_terms.push_back(make_term(a_coeff[ia], a_expo[ia]));
            ia++;
         end else if (a_expo[ia] < b_expo[ib]) begin
            run_terms.push_back(make_term(b_coeff[ib], b_expo[ib]));
            ib++;
         end else begin
            total = int'(a_coeff[ia]) + int'(b_coeff[ib]);
            if (total != 0)
               run_terms.push_back(make_term(total[16:0], a_expo[ia]));
            ia++;
            ib++;
         end
      end
      while (ia < a_count) begin
         run_terms.push_back(make_term(a_coeff[ia], a_expo[ia]));
         ia++;
      end
      while (ib < b_count) begin
         run_terms.push_back(make_term(b_coeff[ib], b_expo[ib]));
         ib++;
      end
      // nothing left: a single zero term flagged empty
      if (run_terms.size() == 0) begin
         t = make_term('0, '0);
         t.empty = 1'b1;
         run_terms.push_back(t);
         empty_runs++;
      end
      for (k = 0; k < run_terms.size(); k++) begin
         t = run_terms[k];
         t.last = (k == run_terms.size() - 1);
         sum_terms_due.push_back(t);
      end
      runs_seen++;
      if (load_dropped)
         overflow_runs++;
      a_count      = 0;
      b_count      = 0;
      load_dropped = 1'b0;
   endtask

   task automatic predict_request(logic [1:0] action, logic signed [15:0] coeff,
                                  logic [15:0] expo);
      case (action)
         ACT_LOAD_A: begin
            if (a_count < MAX_TERMS) begin
               a_coeff[a_count] = coeff;
               a_expo[a_count]  = expo;
               a_count++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         ACT_LOAD_B: begin
            if (b_count < MAX_TERMS) begin
               b_coeff[b_count] = coeff;
               b_expo[b_count]  = expo;
               b_count++;
            end else begin
               load_dropped = 1'b1;
            end
         end
         ACT_RUN: merge_polys();
         default: ;   // unused action: no effect at all
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Driver: new item at the falling edge once the previous one was taken.
   // Valid is only ever assigned once per falling edge.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin : driver
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            nxt = req_backlog.pop_front();
            req_valid      <= 1'b1;
            req_action     <= nxt.action;
            req_term_coeff <= nxt.coeff;
            req_term_exp   <= nxt.expo;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver back-pressure
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // Monitor: results are checked first, then the accepted request is fed
   // to the predictor. A run's terms can never leave in its own accept cycle.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      sum_term_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            terms_seen++;
            if (sum_terms_due.size() == 0) begin
               flag_mismatch("term with nothing expected, sum_coeff", rsp_sum_coeff, 0);
            end else begin
               want = sum_terms_due.pop_front();
               if (rsp_sum_coeff !== want.coeff)
                  flag_mismatch("sum_coeff", rsp_sum_coeff, $signed(want.coeff));
               if (rsp_sum_exp !== want.expo)
                  flag_mismatch("sum_exp", rsp_sum_exp, want.expo);
               if (rsp_last_term !== want.last)
                  flag_mismatch("last_term", rsp_last_term, want.last);
               if (rsp_empty_sum !== want.empty)
                  flag_mismatch("empty_sum", rsp_empty_sum, want.empty);
               if (rsp_overflow !== want.ovf)
                  flag_mismatch("overflow", rsp_overflow, want.ovf);
            end
         end
         if (req_valid && req_ready)
            predict_request(req_action, req_term_coeff, req_term_exp);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   task automatic queue_req(logic [1:0] action, logic signed [15:0] coeff,
                            logic [15:0] expo);
      req_item_type it;
      it.action = action;
      it.coeff  = coeff;
      it.expo   = expo;
      req_backlog.push_back(it);
      items_queued++;
      if (action != ACT_UNUSED)
         useful_items++;
   endtask

   // biased toward the coefficient extremes and zero
   function automatic logic signed [15:0] pick_coeff();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 11))
         0:       return 16'sh0000;
         1:       return 16'sh7FFF;
         2:       return 16'sh8000;
         default: return r[15:0];
      endcase
   endfunction

   // small lists; capacity is covered by the overfilled pair
   function automatic int pick_size();
      return $urandom_range(0, 6);
   endfunction

   // One well-formed load sequence: two descending lists with top exponents
   // at most two apart, loads interleaved at random, then a run. Close exponent
   // steps give lots of equal heads; some of those get a negated coefficient so
   // the pair cancels. Once in a while list A is left out of order, and
   // unused actions are sprinkled in as noise.
   task automatic queue_poly_pair(int na, int nb, bit close_steps);
      logic signed [15:0] ca [$];
      logic signed [15:0] cb [$];
      logic [15:0]        ea [$];
      logic [15:0]        eb [$];
      logic signed [15:0] c;
      logic signed [15:0] swap_c;
      logic [15:0]        swap_e;
      logic [31:0]        r;
      int                 top;
      int                 gap;
      int                 cur;
      int                 k;
      int                 m;
      int                 ia;
      int                 ib;
      top = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(120, 65535);
      gap = close_steps ? 3 : 1500;
      cur = top;
      while (ea.size() < na && cur >= 0) begin
         ea.push_back(cur[15:0]);
         ca.push_back(pick_coeff());
         cur -= $urandom_range(1, gap);
      end
      cur = top - $urandom_range(0, 2);
      while (eb.size() < nb && cur >= 0) begin
         c = pick_coeff();
         for (k = 0; k < ea.size(); k++)
            if (ea[k] == cur[15:0] && $urandom_range(0, 2) == 0)
               c = -ca[k];
         eb.push_back(cur[15:0]);
         cb.push_back(c);
         cur -= $urandom_range(1, gap);
      end
      if (ea.size() >= 2 && $urandom_range(0, 7) == 0) begin
         k = $urandom_range(0, ea.size() - 1);
         m = $urandom_range(0, ea.size() - 1);
         swap_e = ea[k];
         swap_c = ca[k];
         ea[k]  = ea[m];
         ca[k]  = ca[m];
         ea[m]  = swap_e;
         ca[m]  = swap_c;
      end
      ia = 0;
      ib = 0;
      while (ia < ea.size() || ib < eb.size()) begin
         if ($urandom_range(0, 19) == 0) begin
            r = $urandom;
            queue_req(ACT_UNUSED, r[15:0], r[31:16]);
         end
         if (ib >= eb.size() || (ia < ea.size() && $urandom_range(0, 1) == 0)) begin
            queue_req(ACT_LOAD_A, ca[ia], ea[ia]);
            ia++;
         end else begin
            queue_req(ACT_LOAD_B, cb[ib], eb[ib]);
            ib++;
         end
      end
      // payload of a run is ignored by the block; keep it random anyway
      r = $urandom;
      queue_req(ACT_RUN, r[15:0], r[31:16]);
   endtask

   // Short directed opener
   task automatic queue_directed();
      // run with both stores empty: one empty-flagged term
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
      // coefficient and exponent extremes, sums at both ends of 17 bits
      queue_req(ACT_LOAD_A, 16'sh7FFF, 16'hFFFF);
      queue_req(ACT_LOAD_A, 16'sh8000, 16'h0000);
      queue_req(ACT_LOAD_B, 16'sh7FFF, 16'hFFFF);
      queue_req(ACT_LOAD_B, 16'sh8000, 16'h0000);
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
      // cancelling pair drops out, a loaded zero coefficient stays,
      // unused action in the middle changes nothing
      queue_req(ACT_LOAD_A, 16'sd5, 16'd100);
      queue_req(ACT_LOAD_A, 16'sd0, 16'd50);
      queue_req(ACT_UNUSED, -16'sd1, 16'hFFFF);
      queue_req(ACT_LOAD_B, -16'sd5, 16'd100);
      queue_req(ACT_RUN, 16'sh7FFF, 16'hFFFF);
      // everything cancels: empty result
      queue_req(ACT_LOAD_A, 16'sd7, 16'd3);
      queue_req(ACT_LOAD_B, -16'sd7, 16'd3);
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
      // list A ascending: merge order, not sorted order
      queue_req(ACT_LOAD_A, 16'sd1, 16'd5);
      queue_req(ACT_LOAD_A, 16'sd2, 16'd10);
      queue_req(ACT_LOAD_B, 16'sd3, 16'd7);
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
      // repeated exponent within a list
      queue_req(ACT_LOAD_A, 16'sd1, 16'd4);
      queue_req(ACT_LOAD_A, 16'sd2, 16'd4);
      queue_req(ACT_LOAD_B, 16'sd3, 16'd4);
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
      // second polynomial only
      queue_req(ACT_LOAD_B, -16'sd1, 16'h8000);
      queue_req(ACT_RUN, 16'sh0000, 16'h0000);
   endtask

   // Sender holds off here until every predicted term is out
   task automatic wait_idle();
      while (req_backlog.size() != 0 || req_valid || sum_terms_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Four phases: free flow, slow sender, slow receiver, both slow
   task automatic run_phases();
      int p;
      int phase_start;
      int k;
      for (p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 66; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 66; end
            default: begin send_idle_pct = 35; recv_stall_pct = 35; end
         endcase
         if (p == 0)
            queue_directed();
         // both stores overfilled, long back-pressured run with overflow set;
         // close steps so every requested term fits below the top exponent
         if (p == 2)
            queue_poly_pair(34, 33, 1'b1);
         phase_start = useful_items;
         while (useful_items - phase_start < PHASE_ITEMS)
            queue_poly_pair(pick_size(), pick_size(), $urandom_range(0, 1));
         // loads left without a run must not produce anything
         if (p == 3)
            for (k = 0; k < 3; k++)
               queue_req(ACT_LOAD_A, pick_coeff(), 16'($urandom_range(0, 65535)));
         wait_idle();
      end
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : main
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      fork
         run_phases();
         wait (cycle_count >= CYCLE_LIMIT);
      join_any
      if (cycle_count >= CYCLE_LIMIT)
         flag_mismatch("timeout, cycles run", cycle_count, CYCLE_LIMIT);
      if (sum_terms_due.size() != 0)
         flag_mismatch("terms never emitted", sum_terms_due.size(), 0);
      $display("Covered %0d request items in %0d runs (%0d with dropped loads, %0d empty),",
               items_queued, runs_seen, overflow_runs, empty_runs);
      $display("%0d sum terms checked over four idle/stall phases, %0d errors.",
               terms_seen, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/spa_pkg.sv
rtl/core/spa_front.sv
rtl/core/spa_queue.sv
rtl/core/spa_back.sv
rtl/core/sparse_polynomial_add_top.sv
dv/sparse_polynomial_add_top_tb.sv
